[design/utf8_decoder_latin1_fallback_assert.svh]
// Assertion macros for the UTF-8 decoder with Latin-1 fallback.
`ifndef UTF8_DECODER_LATIN1_FALLBACK_ASSERT_SVH
`define UTF8_DECODER_LATIN1_FALLBACK_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks an implication on every clock edge outside reset.
`define UTF8D_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("utf8 decoder assertion failed");
// Checks that a condition in one cycle leads to another in the next cycle.
`define UTF8D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("utf8 decoder assertion failed");
`else
`define UTF8D_ASSERT(label, prop)
`define UTF8D_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/utf8d_pkg.sv]
// Package with types, constants and helper functions of the UTF-8 decoder.
package utf8d_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int LEN_W      = 3;
    localparam int PEND_DEPTH = 3;   // a lead plus at most two continuations
    localparam int PCNT_W     = 2;
    localparam int PCODE_W    = 15;  // payload bits of at most three buffered bytes
    localparam int OUT_MAX    = 4;
    localparam int OCNT_W     = 3;
    localparam int OIDX_W     = 2;

    localparam logic [LEN_W-1:0] LEN_BAD  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] byte_length;
        logic             raw_fallback;
    } result_t;

    // Control part of the buffered sequence.
    typedef struct packed {
        logic [PCNT_W-1:0]  count;
        logic [LEN_W-1:0]   need;
        logic [PCODE_W-1:0] code;
    } pend_t;

    // Sequence length a byte announces in lead position; LEN_BAD when it is no lead.
    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        len = LEN_BAD;
        if (b[7] == 1'b0) begin
            len = LEN_ONE;
        end else if (b[7:5] == 3'b110) begin
            len = LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
            len = LEN_THREE;
        end else if (b[7:3] == 5'b11110) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    // Payload bits of a multi-byte lead.
    function automatic logic [PCODE_W-1:0] lead_payload(input logic [BYTE_W-1:0] b);
        logic [PCODE_W-1:0] p;
        p = '0;
        if (b[7:5] == 3'b110) begin
            p = {{(PCODE_W-5){1'b0}}, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            p = {{(PCODE_W-4){1'b0}}, b[3:0]};
        end else begin
            p = {{(PCODE_W-3){1'b0}}, b[2:0]};
        end
        return p;
    endfunction

    function automatic result_t raw_result(input logic [BYTE_W-1:0] b,
                                           input logic           bad);
        result_t r;
        r.code_point   = {{(CP_W-BYTE_W){1'b0}}, b};
        r.byte_length  = LEN_ONE;
        r.raw_fallback = bad;
        return r;
    endfunction

endpackage

[design/utf8d_decode.sv]
// Single-pass decode of one byte against the buffered sequence.
module utf8d_decode (
    input  utf8d_pkg::pend_t                        pend,
    input  logic [utf8d_pkg::BYTE_W-1:0]            pbytes [utf8d_pkg::PEND_DEPTH],
    input  logic [utf8d_pkg::BYTE_W-1:0]            in_byte,
    input  logic                                    in_eot,
    output utf8d_pkg::result_t                      results [utf8d_pkg::OUT_MAX],
    output logic [utf8d_pkg::OCNT_W-1:0]            result_count,
    output utf8d_pkg::pend_t                        pend_next,
    output logic [utf8d_pkg::BYTE_W-1:0]            pbytes_next [utf8d_pkg::PEND_DEPTH]
);

    logic [utf8d_pkg::LEN_W-1:0] blen;
    logic                        is_cont;
    logic                        is_lead;
    logic [utf8d_pkg::LEN_W-1:0] filled;
    logic                        seq_done;
    logic                        seq_wait;
    logic                        fresh_has;
    utf8d_pkg::result_t          fresh_res;

    assign blen    = utf8d_pkg::lead_len(in_byte);
    assign is_cont = (in_byte[7:6] == 2'b10);
    assign is_lead = (blen != utf8d_pkg::LEN_BAD) && (blen != utf8d_pkg::LEN_ONE);
    assign filled  = {1'b0, pend.count} + utf8d_pkg::LEN_W'(1);

    // A buffered sequence either completes, keeps waiting, or falls back.
    assign seq_done = (pend.count != '0) && is_cont && (filled == pend.need);
    assign seq_wait = (pend.count != '0) && is_cont && (filled < pend.need) && !in_eot;

    // The new byte decoded on its own; a lead that must wait yields nothing.
    always_comb begin
        fresh_has = 1'b1;
        fresh_res = utf8d_pkg::raw_result(in_byte, 1'b1);
        if (blen == utf8d_pkg::LEN_ONE) begin
            fresh_res = utf8d_pkg::raw_result(in_byte, 1'b0);
        end else if (is_lead && !in_eot) begin
            fresh_has = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < utf8d_pkg::OUT_MAX; i++) begin
            results[i] = fresh_res;
        end
        for (int i = 0; i < utf8d_pkg::PEND_DEPTH; i++) begin
            pbytes_next[i] = pbytes[i];
        end
        result_count = '0;
        pend_next    = '0;

        if (seq_done) begin
            results[0].code_point   = {pend.code, in_byte[5:0]};
            results[0].byte_length  = pend.need;
            results[0].raw_fallback = 1'b0;
            result_count            = utf8d_pkg::OCNT_W'(1);
        end else if (seq_wait) begin
            pend_next.count       = pend.count + utf8d_pkg::PCNT_W'(1);
            pend_next.need        = pend.need;
            pend_next.code        = {pend.code[utf8d_pkg::PCODE_W-7:0], in_byte[5:0]};
            pbytes_next[pend.count] = in_byte;
        end else begin
            // Fallback: every buffered byte comes out raw (the lead is bad now and
            // its continuations are bad leads), then the new byte starts afresh.
            for (int i = 0; i < utf8d_pkg::PEND_DEPTH; i++) begin
                if (i < int'(pend.count)) begin
                    results[i] = utf8d_pkg::raw_result(pbytes[i], 1'b1);
                end
            end
            results[pend.count] = fresh_res;
            result_count = {1'b0, pend.count} + {{(utf8d_pkg::OCNT_W-1){1'b0}}, fresh_has};
            if (!fresh_has) begin
                pend_next.count = utf8d_pkg::PCNT_W'(1);
                pend_next.need  = blen;
                pend_next.code  = utf8d_pkg::lead_payload(in_byte);
                pbytes_next[0]  = in_byte;
            end
        end
    end

endmodule

[design/utf8_decoder_latin1_fallback.sv]
// Top level of the UTF-8 decoder with Latin-1 fallback.
//
//  channel | direction | tdata                              | tuser        | tlast
//  --------+-----------+------------------------------------+--------------+------------
//  s_      | in        | [7:0] byte_value                   | -            | end_of_text
//  m_      | out       | [20:0] code_point, [23:21] length  | raw_fallback | last_result
//
// Each byte is decoded in the cycle it is accepted into a four-entry result
// register, so plain text runs at one word per cycle. A byte that yields k words
// (a fallback replays up to four) holds that register until all k have left, and
// the next byte is taken in the cycle its last word leaves. Back-pressure on m_
// holds the current word and stalls input until that last word goes. Reset
// (aresetn low, synchronous) empties the sequence buffer and the result register.
`include "utf8_decoder_latin1_fallback_assert.svh"

module utf8_decoder_latin1_fallback (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] byte_length
    output logic        m_tuser,   // [0] raw_fallback
    output logic        m_tlast    // last_result
);

    // Buffered sequence: lead plus continuations collected so far.
    utf8d_pkg::pend_t                 pend_reg, pend_next;
    logic [utf8d_pkg::BYTE_W-1:0]     pbytes_reg  [utf8d_pkg::PEND_DEPTH];
    logic [utf8d_pkg::BYTE_W-1:0]     pbytes_next [utf8d_pkg::PEND_DEPTH];

    // Result register: the words of one input byte, sent out in order.
    utf8d_pkg::result_t               res_reg [utf8d_pkg::OUT_MAX];
    utf8d_pkg::result_t               dec_res [utf8d_pkg::OUT_MAX];
    logic [utf8d_pkg::OCNT_W-1:0]     dec_count;
    logic [utf8d_pkg::OCNT_W-1:0]     cnt_reg, cnt_next;
    logic [utf8d_pkg::OIDX_W-1:0]     rd_reg, rd_next;
    utf8d_pkg::result_t               head;

    logic s_fire;
    logic m_fire;

    utf8d_decode u_decode (
        .pend         (pend_reg),
        .pbytes       (pbytes_reg),
        .in_byte      (s_tdata),
        .in_eot       (s_tlast),
        .results      (dec_res),
        .result_count (dec_count),
        .pend_next    (pend_next),
        .pbytes_next  (pbytes_next)
    );

    // A new byte may enter when the result register is empty or its last word
    // is leaving in this cycle.
    assign m_tvalid = (cnt_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == utf8d_pkg::OCNT_W'(1)) && m_tready);
    assign s_fire   = s_tvalid && s_tready;

    assign head     = res_reg[rd_reg];
    assign m_tdata  = {head.byte_length, head.code_point};
    assign m_tuser  = head.raw_fallback;
    assign m_tlast  = (cnt_reg == utf8d_pkg::OCNT_W'(1));

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (s_fire) begin
            cnt_next = dec_count;
            rd_next  = '0;
        end else if (m_fire) begin
            cnt_next = cnt_reg - utf8d_pkg::OCNT_W'(1);
            rd_next  = rd_reg + utf8d_pkg::OIDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            cnt_reg  <= '0;
            rd_reg   <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            if (s_fire) begin
                pend_reg <= pend_next;
            end
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pbytes_reg <= pbytes_next;
            res_reg    <= dec_res;
        end
    end

    // The buffer never holds a finished sequence.
    `UTF8D_ASSERT(a_pend_short, (pend_reg.count != '0) |-> ({1'b0, pend_reg.count} < pend_reg.need))
    // The first buffered byte is always a multi-byte lead.
    `UTF8D_ASSERT(a_pend_lead, (pend_reg.count != '0) |-> (pbytes_reg[0][7:6] == 2'b11))
    // A byte marked as the end of the text leaves the buffer empty.
    `UTF8D_ASSERT_NEXT(a_eot_flush, s_fire && s_tlast, pend_reg.count == '0)

endmodule

[bench/testbench.sv]
// Self-checking testbench for the UTF-8 decoder with Latin-1 fallback.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The slowest legal run is far below this. Every byte can yield four words,
    // and each word can wait out a random receiver stall.
    localparam int CYCLE_LIMIT = 300000;

    // One expected or observed output word, in the order of the port fields.
    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0]  code_point;
        logic [utf8d_pkg::LEN_W-1:0] byte_length;
        logic                        raw_fallback;
        logic                        last_result;
    } code_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] byte_value
    logic        s_tlast;    // end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [20:0] code_point, [23:21] byte_length
    logic        m_tuser;    // [0] raw_fallback
    logic        m_tlast;    // last_result

    // Words the decoder owes us, oldest first.
    code_word_t  predicted_code_points[$];
    // Bytes of a sequence that is still waiting for its continuations.
    logic [7:0]  partial_sequence[$];

    int          mismatches = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    // Knobs set by the test tasks and read by the sender task and the receiver process.
    bit          sender_gaps = 1'b0;
    bit          ready_stalls = 1'b0;
    int          ready_holdoff = 0;

    utf8_decoder_latin1_fallback dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Hard stop in case the decoder hangs on either channel.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void add_code_word(input logic [utf8d_pkg::CP_W-1:0] cp,
                                          input logic [utf8d_pkg::LEN_W-1:0] len,
                                          input logic raw);
        code_word_t w;
        w.code_point   = cp;
        w.byte_length  = len;
        w.raw_fallback = raw;
        w.last_result  = 1'b0;
        predicted_code_points = {predicted_code_points, w};
    endfunction

    // Decodes the buffered bytes plus the new one. Whatever cannot be
    // finished yet stays in partial_sequence; a lead that can never be
    // finished comes out raw and decoding restarts at the byte after it.
    function automatic void decode_byte(input logic [7:0] new_byte, input logic eot);
        logic [7:0]                  seq[$];
        logic [7:0]                  lead;
        logic [utf8d_pkg::CP_W-1:0]  cp;
        logic [utf8d_pkg::LEN_W-1:0] need;
        int                          head;
        int                          avail;
        int                          take;
        int                          i;
        int                          first_new;
        bit                          good;
        bit                          waiting;
        seq = partial_sequence;
        seq = {seq, new_byte};
        first_new = predicted_code_points.size();
        head = 0;
        waiting = 1'b0;
        while (head < seq.size() && !waiting) begin
            lead  = seq[head];
            avail = seq.size() - head;
            cp    = '0;
            if (lead[7] == 1'b0) begin
                need = utf8d_pkg::LEN_ONE;
            end else if (lead[7:5] == 3'b110) begin
                need = utf8d_pkg::LEN_TWO;
                cp   = utf8d_pkg::CP_W'(lead & 8'h1F);
            end else if (lead[7:4] == 4'b1110) begin
                need = utf8d_pkg::LEN_THREE;
                cp   = utf8d_pkg::CP_W'(lead & 8'h0F);
            end else if (lead[7:3] == 5'b11110) begin
                need = utf8d_pkg::LEN_FOUR;
                cp   = utf8d_pkg::CP_W'(lead & 8'h07);
            end else begin
                need = utf8d_pkg::LEN_BAD;
            end

            if (need == utf8d_pkg::LEN_ONE) begin
                add_code_word(utf8d_pkg::CP_W'(lead), utf8d_pkg::LEN_ONE, 1'b0);
                head++;
            end else if (need == utf8d_pkg::LEN_BAD) begin
                add_code_word(utf8d_pkg::CP_W'(lead), utf8d_pkg::LEN_ONE, 1'b1);
                head++;
            end else begin
                take = (avail < need) ? avail : need;
                good = 1'b1;
                for (i = 1; i < take && good; i++) begin
                    if (seq[head + i][7:6] != 2'b10) begin
                        good = 1'b0;
                    end else begin
                        cp = (cp << 6) | utf8d_pkg::CP_W'(seq[head + i][5:0]);
                    end
                end
                if (!good || (avail < need && eot)) begin
                    add_code_word(utf8d_pkg::CP_W'(lead), utf8d_pkg::LEN_ONE, 1'b1);
                    head++;
                end else if (avail < need) begin
                    waiting = 1'b1;
                end else begin
                    add_code_word(cp, need, 1'b0);
                    head += need;
                end
            end
        end
        partial_sequence.delete();
        for (i = head; i < seq.size(); i++) begin
            partial_sequence = {partial_sequence, seq[i]};
        end
        if (predicted_code_points.size() > first_new) begin
            predicted_code_points[predicted_code_points.size() - 1].last_result = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one byte and returns at the rising edge where it was taken.
    // The handshake is sampled on the falling edge, where nothing moves,
    // and the prediction is made there too, before any of its words can
    // show up on the result channel.
    task automatic send_byte(input logic [7:0] value, input logic eot);
        bit taken;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= eot;
        do begin
            @(negedge aclk);
            taken = s_tready;
            if (taken) begin
                decode_byte(value, eot);
                bytes_sent++;
            end
            @(posedge aclk);
        end while (!taken);
    endtask

    // Drops valid and holds the sender until every owed word has left.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (predicted_code_points.size() != 0) @(posedge aclk);
    endtask

    // Sends one character of random content. A clean one is well formed;
    // a noisy one is a stray byte, a sequence cut short, or a sequence
    // with a broken continuation.
    task automatic send_text_unit(input bit noisy);
        logic [7:0]  unit_bytes[4];
        logic [31:0] r;
        int          unit_len;
        int          flaw;
        int          i;
        int          eot_odds;
        unit_len = $urandom_range(1, 4);
        for (i = 0; i < 4; i++) begin
            r = $urandom;
            unit_bytes[i] = {2'b10, r[5:0]};
        end
        r = $urandom;
        case (unit_len)
            1: unit_bytes[0] = {1'b0, r[6:0]};
            2: unit_bytes[0] = {3'b110, r[4:0]};
            3: unit_bytes[0] = {4'b1110, r[3:0]};
            default: unit_bytes[0] = {5'b11110, r[2:0]};
        endcase
        eot_odds = 6;
        if (noisy) begin
            flaw = $urandom_range(0, 2);
            eot_odds = 3;
            if (flaw == 0 || unit_len == 1) begin
                r = $urandom;
                unit_bytes[0] = r[7:0];
                unit_len = 1;
            end else if (flaw == 1) begin
                unit_len = $urandom_range(1, unit_len - 1);
            end else begin
                i = $urandom_range(1, unit_len - 1);
                r = $urandom;
                if (r[7:6] == 2'b10) r[6] = 1'b1;
                unit_bytes[i] = r[7:0];
            end
        end
        for (i = 0; i < unit_len; i++) begin
            send_byte(unit_bytes[i],
                      (i == unit_len - 1) && ($urandom_range(1, eot_odds) == 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver takes words freely, stalls in short random bursts when
    // asked, and honors a long hold-off counted here in cycles.
    initial begin : result_receiver
        int stall_len;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (ready_holdoff > 0) begin
                stall_len = ready_holdoff;
                ready_holdoff = 0;
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end else if (ready_stalls && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
    endtask

    // The word on the bus is captured on the falling edge and checked on
    // the next rising edge, which is where the handshake completes.
    always begin : result_checker
        bit         seen;
        code_word_t got;
        code_word_t want;
        @(negedge aclk);
        seen = aresetn && m_tvalid && m_tready;
        got  = {m_tdata[20:0], m_tdata[23:21], m_tuser, m_tlast};
        @(posedge aclk);
        if (seen) begin
            if (predicted_code_points.size() == 0) begin
                mismatches++;
                $display("%0t: expected no word, got code_point %h length %0d raw %b last %b",
                         $time, got.code_point, got.byte_length, got.raw_fallback,
                         got.last_result);
            end else begin
                want = predicted_code_points.pop_front();
                if (got.code_point !== want.code_point)
                    report_field("code_point", want.code_point, got.code_point);
                if (got.byte_length !== want.byte_length)
                    report_field("byte_length", want.byte_length, got.byte_length);
                if (got.raw_fallback !== want.raw_fallback)
                    report_field("raw_fallback", want.raw_fallback, got.raw_fallback);
                if (got.last_result !== want.last_result)
                    report_field("last_result", want.last_result, got.last_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked strings: field extremes, each sequence length and each
    // way a sequence can fail.
    task automatic test_directed_strings();
        ready_stalls = 1'b1;
        // ASCII at both ends of its range.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // Complete two, three and four byte characters.
        send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // Largest payload a four byte form can carry, ending the string.
        send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // Bytes that can never lead: a stray continuation and the top leads.
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Broken continuation that is plain ASCII.
        send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
        // Broken continuation that is itself a good lead.
        send_byte(8'hE0, 1'b0); send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
        // Three raw bytes and an ASCII byte: four words from one byte.
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
        send_byte(8'h41, 1'b0);
        // Strings that end in the middle of a sequence, and on a lone lead.
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
        send_byte(8'hC0, 1'b1);
        wait_drained();
    endtask

    // Mostly well-formed text of random content, with some noise, while
    // both sides idle at random.
    task automatic test_random_text();
        int start;
        sender_gaps  = 1'b1;
        ready_stalls = 1'b1;
        start = bytes_sent;
        while (bytes_sent - start < 20) begin
            send_text_unit($urandom_range(0, 4) == 0);
        end
        wait_drained();
    endtask

    // The receiver stops for a long time while broken sequences that release
    // four words from one byte keep coming, so the decoder must stall its input.
    task automatic test_output_backpressure();
        int i;
        sender_gaps  = 1'b0;
        ready_stalls = 1'b0;
        ready_holdoff = 90;
        for (i = 0; i < 6; i++) begin
            send_byte(8'hF0, 1'b0);
            send_byte(8'h9F, 1'b0);
            send_byte(8'h98, 1'b0);
            send_byte(8'h41, 1'b0);
            send_byte(8'hBF, 1'b0);
        end
        wait_drained();
    endtask

    // A stretch at full rate on both sides.
    task automatic test_full_rate();
        int i;
        sender_gaps  = 1'b0;
        ready_stalls = 1'b0;
        for (i = 0; i < 8; i++) begin
            send_text_unit($urandom_range(0, 3) == 0);
        end
        wait_drained();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_strings();
        test_random_text();
        test_output_backpressure();
        test_full_rate();

        // Let any stray word show itself before the verdict.
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && predicted_code_points.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
